### hw/rtl/bpsm_pkg.sv
// Shared types, constants and helpers for the buffer pool slot manager.
package bpsm_pkg;

  localparam int SLOT_COUNT = 128;
  localparam int SIDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [63:0] POOL_BASE = 64'h0000_0000_8000_0000;
  localparam logic [28:0] CAP_RESET = 29'd268435456;

  typedef logic [SIDX_W-1:0] sidx_t;

  typedef enum logic [2:0] {
    CMD_ALLOC    = 3'd0,
    CMD_FREE     = 3'd1,
    CMD_FIND     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_FREE_ALL = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NOCAP    = 3'd2,
    ST_NOSLOT   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BOUNDS   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INC,
    OP_RD_CNT,
    OP_RD_SIDX,
    OP_ALLOC,
    OP_FREE,
    OP_FIND,
    OP_RW,
    OP_FREE_ALL,
    OP_REPORT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       size_zero;
    logic       no_cap;
    logic       cur_free;
    logic       cnt_last;
    logic       match;
    logic       sidx_ok;
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] session;
    logic [63:0] base;
    logic [28:0] length;
    logic [28:0] high_water;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  function automatic logic [6:0] slot7(sidx_t s);
    logic [31:0] t;
    t = 32'(s);
    return t[6:0];
  endfunction

endpackage

### hw/rtl/bpsm_ram.sv
// Generic single write port, single read port RAM with registered read.
module bpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bpsm_datapath.sv
// Datapath: captured command, slot table, scan counter, pool totals, results.
module bpsm_datapath import bpsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [28:0] cfg_wdata_i,
  input  logic [2:0]  command_i,
  input  logic [28:0] size_bytes_i,
  input  logic [31:0] session_id_i,
  input  logic [31:0] buffer_id_i,
  input  logic [6:0]  slot_index_i,
  input  logic [28:0] offset_bytes_i,
  input  logic [28:0] length_bytes_i,
  input  dp_cmd_t     dp_cmd_i,
  output dp_stat_t    dp_stat_o,
  output logic [2:0]  status_o,
  output logic [6:0]  slot_out_o,
  output logic [31:0] id_out_o,
  output logic [63:0] address_out_o,
  output logic [28:0] buffer_size_out_o,
  output logic [28:0] buffer_used_out_o,
  output logic [28:0] pool_used_out_o,
  output logic [28:0] pool_peak_out_o,
  output logic [7:0]  active_count_out_o
);

  logic [2:0]  cmd_q;
  logic [28:0] size_q, off_q, len_q;
  logic [31:0] sess_q, bid_q;
  logic [6:0]  sidx_in_q;

  logic [28:0]           cap_q, pool_used_q, pool_peak_q;
  logic [31:0]           next_id_q;
  logic [63:0]           next_base_q;
  logic [CNT_W-1:0]      active_q;
  logic [SLOT_COUNT-1:0] valid_q;
  sidx_t                 cnt_q;

  logic [2:0]  res_status_q;
  sidx_t       res_slot_q;
  logic [31:0] res_id_q;
  logic [63:0] res_addr_q;
  logic [28:0] res_size_q, res_used_q;

  slot_entry_t rd_entry, wr_entry;
  logic        ram_we, ram_re;
  sidx_t       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [31:0] sidx_wide;
  sidx_t       sidx_a;
  logic        sidx_in_range;
  logic [29:0] rw_end;
  logic        rw_bad, hw_raise;
  logic [28:0] alloc_used;
  logic [28:0] rw_hw;

  assign sidx_wide     = 32'(sidx_in_q);
  assign sidx_a        = sidx_wide[SIDX_W-1:0];
  assign sidx_in_range = sidx_wide < 32'(SLOT_COUNT);
  assign rd_entry      = slot_entry_t'(ram_rdata);

  assign rw_end   = {1'b0, off_q} + {1'b0, len_q};
  assign rw_bad   = rw_end > {1'b0, rd_entry.length};
  assign hw_raise = (cmd_q == CMD_WRITE) && !rw_bad && (rw_end > {1'b0, rd_entry.high_water});
  assign rw_hw    = hw_raise ? rw_end[28:0] : rd_entry.high_water;
  assign alloc_used = pool_used_q + size_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    wr_entry  = rd_entry;
    if (dp_cmd_i.op == OP_ALLOC) begin
      ram_we              = 1'b1;
      wr_entry.ident      = next_id_q;
      wr_entry.session    = sess_q;
      wr_entry.base       = next_base_q;
      wr_entry.length     = size_q;
      wr_entry.high_water = '0;
    end else if (dp_cmd_i.op == OP_RW) begin
      ram_we              = hw_raise;
      ram_waddr           = sidx_a;
      wr_entry.high_water = rw_hw;
    end
  end

  assign ram_re    = (dp_cmd_i.op == OP_RD_CNT) || (dp_cmd_i.op == OP_RD_SIDX);
  assign ram_raddr = (dp_cmd_i.op == OP_RD_SIDX) ? sidx_a : cnt_q;

  bpsm_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    dp_stat_o.cmd       = cmd_q;
    dp_stat_o.size_zero = size_q == '0;
    dp_stat_o.no_cap    = ({1'b0, pool_used_q} + {1'b0, size_q}) > {1'b0, cap_q};
    dp_stat_o.cur_free  = !valid_q[cnt_q];
    dp_stat_o.cnt_last  = cnt_q == SIDX_W'(SLOT_COUNT - 1);
    dp_stat_o.match     = valid_q[cnt_q] &&
        ((cmd_q == CMD_FREE) ? (rd_entry.ident == bid_q) : (rd_entry.session == sess_q));
    dp_stat_o.sidx_ok   = sidx_in_range && valid_q[sidx_a];
  end

  // control and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      pool_used_q <= '0;
      pool_peak_q <= '0;
      next_id_q   <= 32'd1;
      next_base_q <= POOL_BASE;
      active_q    <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      case (dp_cmd_i.op)
        OP_LOAD: cnt_q <= '0;
        OP_INC:  cnt_q <= cnt_q + 1'b1;
        OP_ALLOC: begin
          valid_q[cnt_q] <= 1'b1;
          next_id_q      <= next_id_q + 32'd1;
          next_base_q    <= next_base_q + 64'(size_q);
          pool_used_q    <= alloc_used;
          active_q       <= active_q + 1'b1;
          if (alloc_used > pool_peak_q) begin
            pool_peak_q <= alloc_used;
          end
        end
        OP_FREE: begin
          valid_q[cnt_q] <= 1'b0;
          pool_used_q    <= (pool_used_q >= rd_entry.length) ?
                            pool_used_q - rd_entry.length : '0;
          if (active_q != '0) begin
            active_q <= active_q - 1'b1;
          end
        end
        OP_FREE_ALL: begin
          valid_q     <= '0;
          pool_used_q <= '0;
          active_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  // captured command and result payload
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == OP_LOAD) begin
      cmd_q     <= command_i;
      size_q    <= size_bytes_i;
      sess_q    <= session_id_i;
      bid_q     <= buffer_id_i;
      sidx_in_q <= slot_index_i;
      off_q     <= offset_bytes_i;
      len_q     <= length_bytes_i;
    end
    case (dp_cmd_i.op)
      OP_ALLOC: begin
        res_status_q <= ST_OK;
        res_slot_q   <= cnt_q;
        res_id_q     <= next_id_q;
        res_addr_q   <= next_base_q;
        res_size_q   <= size_q;
        res_used_q   <= '0;
      end
      OP_FREE, OP_FIND: begin
        res_status_q <= ST_OK;
        res_slot_q   <= cnt_q;
        res_id_q     <= rd_entry.ident;
        res_addr_q   <= rd_entry.base;
        res_size_q   <= rd_entry.length;
        res_used_q   <= rd_entry.high_water;
      end
      OP_RW: begin
        res_status_q <= rw_bad ? ST_BOUNDS : ST_OK;
        res_slot_q   <= sidx_a;
        res_id_q     <= rd_entry.ident;
        res_addr_q   <= rd_entry.base;
        res_size_q   <= rd_entry.length;
        res_used_q   <= rw_hw;
      end
      OP_FREE_ALL, OP_REPORT: begin
        res_status_q <= (dp_cmd_i.op == OP_FREE_ALL) ? ST_OK : dp_cmd_i.status;
        res_slot_q   <= '0;
        res_id_q     <= '0;
        res_addr_q   <= '0;
        res_size_q   <= '0;
        res_used_q   <= '0;
      end
      default: ;
    endcase
  end

  assign status_o           = res_status_q;
  assign slot_out_o         = slot7(res_slot_q);
  assign id_out_o           = res_id_q;
  assign address_out_o      = res_addr_q;
  assign buffer_size_out_o  = res_size_q;
  assign buffer_used_out_o  = res_used_q;
  assign pool_used_out_o    = pool_used_q;
  assign pool_peak_out_o    = pool_peak_q;
  assign active_count_out_o = 8'(active_q);

endmodule

### hw/rtl/bpsm_ctrl.sv
// Controller: sequences each command through the datapath.
module bpsm_ctrl import bpsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  input  dp_stat_t dp_stat_i,
  output dp_cmd_t  dp_cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_SCAN,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_RW_CHK
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d         = state_q;
    done_d          = 1'b0;
    dp_cmd_o.op     = OP_NONE;
    dp_cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          dp_cmd_o.op = OP_LOAD;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (dp_stat_i.cmd)
          CMD_ALLOC: begin
            if (dp_stat_i.size_zero || dp_stat_i.no_cap) begin
              dp_cmd_o.op     = OP_REPORT;
              dp_cmd_o.status = dp_stat_i.size_zero ? ST_INVALID : ST_NOCAP;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end else begin
              state_d = S_ALLOC_SCAN;
            end
          end
          CMD_FREE, CMD_FIND: begin
            dp_cmd_o.op = OP_RD_CNT;
            state_d     = S_SRCH_CHK;
          end
          CMD_WRITE, CMD_READ: begin
            if (dp_stat_i.sidx_ok) begin
              dp_cmd_o.op = OP_RD_SIDX;
              state_d     = S_RW_CHK;
            end else begin
              dp_cmd_o.op     = OP_REPORT;
              dp_cmd_o.status = ST_INVALID;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end
          end
          CMD_FREE_ALL: begin
            dp_cmd_o.op = OP_FREE_ALL;
            done_d      = 1'b1;
            state_d     = S_IDLE;
          end
          default: begin
            dp_cmd_o.op     = OP_REPORT;
            dp_cmd_o.status = ST_INVALID;
            done_d          = 1'b1;
            state_d         = S_IDLE;
          end
        endcase
      end
      S_ALLOC_SCAN: begin
        if (dp_stat_i.cur_free) begin
          dp_cmd_o.op = OP_ALLOC;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else if (dp_stat_i.cnt_last) begin
          dp_cmd_o.op     = OP_REPORT;
          dp_cmd_o.status = ST_NOSLOT;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end else begin
          dp_cmd_o.op = OP_INC;
        end
      end
      S_SRCH_RD: begin
        dp_cmd_o.op = OP_RD_CNT;
        state_d     = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (dp_stat_i.match) begin
          dp_cmd_o.op = (dp_stat_i.cmd == CMD_FREE) ? OP_FREE : OP_FIND;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end else if (dp_stat_i.cnt_last) begin
          dp_cmd_o.op     = OP_REPORT;
          dp_cmd_o.status = ST_NOTFOUND;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end else begin
          dp_cmd_o.op = OP_INC;
          state_d     = S_SRCH_RD;
        end
      end
      S_RW_CHK: begin
        dp_cmd_o.op = OP_RW;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;

endmodule

### hw/rtl/buffer_pool_slot_manager.sv
// Top level of the buffer pool slot manager.
//
// Command channel: drive command_i and its operand ports with start high;
// the command transfers at the rising edge where start is high and busy is
// low. Operands are captured then and need not be held afterwards.
// Result channel: done_o is high for exactly one cycle with status and slot
// fields; pool totals are live and valid in that cycle. The receiver cannot
// stall, so results are never held back.
// Config: cfg_we_i writes cfg_wdata_i to the pool capacity register.
// Path from the transfer edge to done_o:
//   free_all, invalid or rejected alloc: decided in dispatch
//   write/read check: one table read
//   alloc: one valid bit checked per cycle
//   free/find: one table read and compare per slot
// One command at a time; the slot scan sets the throughput.
// Reset clears valid bits and totals at once; no clearing pass is needed.
module buffer_pool_slot_manager import bpsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [28:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [28:0] size_bytes_i,
  input  logic [31:0] session_id_i,
  input  logic [31:0] buffer_id_i,
  input  logic [6:0]  slot_index_i,
  input  logic [28:0] offset_bytes_i,
  input  logic [28:0] length_bytes_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [6:0]  slot_out_o,
  output logic [31:0] id_out_o,
  output logic [63:0] address_out_o,
  output logic [28:0] buffer_size_out_o,
  output logic [28:0] buffer_used_out_o,
  output logic [28:0] pool_used_out_o,
  output logic [28:0] pool_peak_out_o,
  output logic [7:0]  active_count_out_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bpsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .done_o    (done_o),
    .dp_stat_i (dp_stat),
    .dp_cmd_o  (dp_cmd)
  );

  bpsm_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .command_i          (command_i),
    .size_bytes_i       (size_bytes_i),
    .session_id_i       (session_id_i),
    .buffer_id_i        (buffer_id_i),
    .slot_index_i       (slot_index_i),
    .offset_bytes_i     (offset_bytes_i),
    .length_bytes_i     (length_bytes_i),
    .dp_cmd_i           (dp_cmd),
    .dp_stat_o          (dp_stat),
    .status_o           (status_o),
    .slot_out_o         (slot_out_o),
    .id_out_o           (id_out_o),
    .address_out_o      (address_out_o),
    .buffer_size_out_o  (buffer_size_out_o),
    .buffer_used_out_o  (buffer_used_out_o),
    .pool_used_out_o    (pool_used_out_o),
    .pool_peak_out_o    (pool_peak_out_o),
    .active_count_out_o (active_count_out_o)
  );

endmodule

### hw/rtl/bpsm_checker.sv
// Port-level checks for the buffer pool slot manager, bound to the top level.
module bpsm_checker import bpsm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic [7:0] active_count_out_o
);

  // a transfer always keeps the block busy for the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // a result ends the command: the block is free in that cycle
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= 3'(ST_BOUNDS)))
    else $error("status code out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(active_count_out_o) <= SLOT_COUNT)
    else $error("active count above slot count");

endmodule

bind buffer_pool_slot_manager bpsm_checker u_bpsm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .done_o             (done_o),
  .status_o           (status_o),
  .active_count_out_o (active_count_out_o)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the buffer pool slot manager.
`timescale 1ns / 100ps

module tb_top;
  import bpsm_pkg::*;

  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE = 300;
  localparam logic [28:0] SZ_MAX = 29'd268435456;

  typedef struct {
    logic [2:0]  cmd;
    logic [28:0] size;
    logic [31:0] sess;
    logic [31:0] bid;
    logic [6:0]  sidx;
    logic [28:0] off;
    logic [28:0] len;
  } cmd_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [31:0] ident;
    logic [63:0] addr;
    logic [28:0] bsize;
    logic [28:0] bused;
    logic [28:0] pused;
    logic [28:0] ppeak;
    logic [7:0]  count;
  } pool_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [28:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] command_i = '0;
  logic [28:0] size_bytes_i = '0;
  logic [31:0] session_id_i = '0;
  logic [31:0] buffer_id_i = '0;
  logic [6:0] slot_index_i = '0;
  logic [28:0] offset_bytes_i = '0;
  logic [28:0] length_bytes_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [6:0] slot_out_o;
  logic [31:0] id_out_o;
  logic [63:0] address_out_o;
  logic [28:0] buffer_size_out_o, buffer_used_out_o;
  logic [28:0] pool_used_out_o, pool_peak_out_o;
  logic [7:0] active_count_out_o;

  buffer_pool_slot_manager uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cmd_item_t   cmd_pending[$];
  pool_reply_t replies_due[$];
  int errors = 0;
  int sent = 0;
  int quiet = 0;
  int allocs_gen = 0;
  logic in_flight = 1'b0;

  // shadow copy of the slot table
  logic [28:0] cap_q;
  logic        t_valid[SLOT_COUNT];
  logic [31:0] t_ident[SLOT_COUNT];
  logic [31:0] t_sess[SLOT_COUNT];
  logic [63:0] t_base[SLOT_COUNT];
  logic [28:0] t_len[SLOT_COUNT];
  logic [28:0] t_hw[SLOT_COUNT];
  logic [31:0] nxt_ident;
  logic [63:0] nxt_base;
  logic [28:0] used_q, peak_q;
  logic [7:0]  count_q;

  task automatic report_slot(input int s, inout pool_reply_t r);
    r.slot = 7'(s);
    r.ident = t_ident[s];
    r.addr = t_base[s];
    r.bsize = t_len[s];
    r.bused = t_hw[s];
  endtask

  task automatic apply_command(input cmd_item_t it, output pool_reply_t r);
    logic [29:0] sum;
    bit hit;
    r = '{default: '0};
    hit = 0;
    case (it.cmd)
      CMD_ALLOC: begin
        sum = {1'b0, used_q} + it.size;
        if (it.size == 0) r.status = ST_INVALID;
        else if (sum > cap_q) r.status = ST_NOCAP;
        else begin
          r.status = ST_NOSLOT;
          for (int i = 0; i < SLOT_COUNT && !hit; i++)
            if (!t_valid[i]) begin
              hit = 1;
              t_valid[i] = 1'b1;
              t_ident[i] = nxt_ident;
              nxt_ident++;
              t_sess[i] = it.sess;
              t_base[i] = nxt_base;
              t_len[i] = it.size;
              t_hw[i] = '0;
              nxt_base += it.size;
              used_q = sum[28:0];
              count_q++;
              if (used_q > peak_q) peak_q = used_q;
              report_slot(i, r);
              r.status = ST_OK;
            end
        end
      end
      CMD_FREE: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < SLOT_COUNT && !hit; i++)
          if (t_valid[i] && t_ident[i] == it.bid) begin
            hit = 1;
            t_valid[i] = 1'b0;
            used_q = (used_q >= t_len[i]) ? used_q - t_len[i] : '0;
            if (count_q > 0) count_q--;
            report_slot(i, r);
            r.status = ST_OK;
          end
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < SLOT_COUNT && !hit; i++)
          if (t_valid[i] && t_sess[i] == it.sess) begin
            hit = 1;
            report_slot(i, r);
            r.status = ST_OK;
          end
      end
      CMD_WRITE, CMD_READ: begin
        if (!t_valid[it.sidx]) r.status = ST_INVALID;
        else begin
          sum = {1'b0, it.off} + it.len;
          if (sum > t_len[it.sidx]) r.status = ST_BOUNDS;
          else begin
            if (it.cmd == CMD_WRITE && sum > t_hw[it.sidx]) t_hw[it.sidx] = sum[28:0];
            r.status = ST_OK;
          end
          report_slot(it.sidx, r);
        end
      end
      CMD_FREE_ALL: begin
        for (int i = 0; i < SLOT_COUNT; i++) t_valid[i] = 1'b0;
        used_q = '0;
        count_q = '0;
        r.status = ST_OK;
      end
      default: r.status = ST_INVALID;
    endcase
    r.pused = used_q;
    r.ppeak = peak_q;
    r.count = count_q;
  endtask

  // transfer detection, prediction and result checking
  always @(posedge clk_i) begin
    cmd_item_t it;
    pool_reply_t exp_r;
    bit act;
    act = 0;
    if (start && !busy) begin
      it.cmd = command_i; it.size = size_bytes_i; it.sess = session_id_i;
      it.bid = buffer_id_i; it.sidx = slot_index_i;
      it.off = offset_bytes_i; it.len = length_bytes_i;
      apply_command(it, exp_r);
      replies_due.push_back(exp_r);
      in_flight <= 1'b0;
      act = 1;
    end
    if (done_o) begin
      act = 1;
      if (replies_due.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        exp_r = replies_due.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, status_o); errors++; end
        if (slot_out_o !== exp_r.slot) begin
          $error("slot_out exp %0d got %0d", exp_r.slot, slot_out_o); errors++; end
        if (id_out_o !== exp_r.ident) begin
          $error("id_out exp %0h got %0h", exp_r.ident, id_out_o); errors++; end
        if (address_out_o !== exp_r.addr) begin
          $error("address_out exp %0h got %0h", exp_r.addr, address_out_o); errors++; end
        if (buffer_size_out_o !== exp_r.bsize) begin
          $error("buffer_size_out exp %0d got %0d", exp_r.bsize, buffer_size_out_o);
          errors++;
        end
        if (buffer_used_out_o !== exp_r.bused) begin
          $error("buffer_used_out exp %0d got %0d", exp_r.bused, buffer_used_out_o);
          errors++;
        end
        if (pool_used_out_o !== exp_r.pused) begin
          $error("pool_used_out exp %0d got %0d", exp_r.pused, pool_used_out_o); errors++; end
        if (pool_peak_out_o !== exp_r.ppeak) begin
          $error("pool_peak_out exp %0d got %0d", exp_r.ppeak, pool_peak_out_o); errors++; end
        if (active_count_out_o !== exp_r.count) begin
          $error("active_count_out exp %0d got %0d", exp_r.count, active_count_out_o);
          errors++;
        end
      end
    end
    quiet <= act ? 0 : quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // command driver; in_flight marks an item still waiting for its transfer
  always @(negedge clk_i) begin
    cmd_item_t it;
    bit go;
    if (rst_ni && !in_flight && !(start && in_flight)) begin
      go = cmd_pending.size() > 0 &&
           ((sent >= 300 && sent < 450) || $urandom_range(0, 99) >= 28);
      if (go) begin
        it = cmd_pending.pop_front();
        command_i <= it.cmd; size_bytes_i <= it.size; session_id_i <= it.sess;
        buffer_id_i <= it.bid; slot_index_i <= it.sidx;
        offset_bytes_i <= it.off; length_bytes_i <= it.len;
        in_flight <= 1'b1;
        sent++;
      end
      start <= go;
    end
  end

  function automatic logic [28:0] rand_bytes();
    if ($urandom_range(0, 7) == 0) return SZ_MAX;
    return 29'($urandom_range(0, 268435455));
  endfunction

  function automatic cmd_item_t mk(logic [2:0] c, logic [28:0] sz = 0, logic [31:0] se = 0,
                                   logic [31:0] b = 0, logic [6:0] si = 0,
                                   logic [28:0] o = 0, logic [28:0] l = 0);
    cmd_item_t it;
    it.cmd = c; it.size = sz; it.sess = se; it.bid = b; it.sidx = si; it.off = o; it.len = l;
    return it;
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int w;
    it = mk(CMD_ALLOC, rand_bytes(), $urandom, $urandom, 7'($urandom), rand_bytes(),
            rand_bytes());
    w = $urandom_range(0, 99);
    if ($urandom_range(0, 3) != 0) it.sess = 32'($urandom_range(0, 7));
    if (w < 36) begin
      it.cmd = CMD_ALLOC;
      if ($urandom_range(0, 5) != 0) it.size = 29'($urandom_range(1, 4096));
      allocs_gen++;
    end else if (w < 56) begin
      it.cmd = CMD_FREE;
      if ($urandom_range(0, 5) != 0) it.bid = 32'($urandom_range(1, allocs_gen + 2));
    end else if (w < 68) it.cmd = CMD_FIND;
    else if (w < 95) begin
      it.cmd = (w < 82) ? CMD_WRITE : CMD_READ;
      if ($urandom_range(0, 3) != 0) begin
        it.sidx = 7'($urandom_range(0, 20));
        it.off = 29'($urandom_range(0, 3000));
        it.len = 29'($urandom_range(0, 3000));
      end
    end else if (w < 97) it.cmd = CMD_FREE_ALL;
    else it.cmd = $urandom_range(0, 1) ? CMD_BAD6 : CMD_BAD7;
    return it;
  endfunction

  task automatic drain();
    wait (cmd_pending.size() == 0 && !in_flight && replies_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [28:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    cap_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [28:0] caps[5];
    cap_q = CAP_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      t_valid[i] = 0; t_ident[i] = 0; t_sess[i] = 0; t_base[i] = 0; t_len[i] = 0; t_hw[i] = 0;
    end
    nxt_ident = 1; nxt_base = POOL_BASE; used_q = 0; peak_q = 0; count_q = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: rejects, capacity edge, lookups, bounds, unknown codes
    cmd_pending.push_back(mk(CMD_ALLOC, 0, 1));
    cmd_pending.push_back(mk(CMD_ALLOC, SZ_MAX, 32'hFFFF_FFFF));
    cmd_pending.push_back(mk(CMD_ALLOC, 1, 2));
    cmd_pending.push_back(mk(CMD_FIND, 0, 32'hFFFF_FFFF));
    cmd_pending.push_back(mk(CMD_WRITE, 0, 0, 0, 0, SZ_MAX, 0));
    cmd_pending.push_back(mk(CMD_WRITE, 0, 0, 0, 0, SZ_MAX, SZ_MAX));
    cmd_pending.push_back(mk(CMD_FREE, 0, 0, 32'd1));
    cmd_pending.push_back(mk(CMD_FREE, 0, 0, 32'd1));
    cmd_pending.push_back(mk(CMD_FREE, 0, 0, 32'hFFFF_FFFF));
    cmd_pending.push_back(mk(CMD_ALLOC, 100, 32'h5A5A_5A5A));
    cmd_pending.push_back(mk(CMD_WRITE, 0, 0, 0, 0, 10, 20));
    cmd_pending.push_back(mk(CMD_WRITE, 0, 0, 0, 0, 0, 100));
    cmd_pending.push_back(mk(CMD_WRITE, 0, 0, 0, 0, 50, 51));
    cmd_pending.push_back(mk(CMD_READ, 0, 0, 0, 0, 99, 1));
    cmd_pending.push_back(mk(CMD_READ, 0, 0, 0, 0, 100, 1));
    cmd_pending.push_back(mk(CMD_READ, 0, 0, 0, 7'd127, 0, 0));
    cmd_pending.push_back(mk(CMD_FIND, 0, 32'h5A5A_5A5A));
    cmd_pending.push_back(mk(CMD_FIND, 0, 32'd0));
    cmd_pending.push_back(mk(CMD_BAD6, 5, 5, 5, 5, 5, 5));
    cmd_pending.push_back(mk(CMD_BAD7));
    cmd_pending.push_back(mk(CMD_FREE_ALL));
    cmd_pending.push_back(mk(CMD_READ));
    cmd_pending.push_back(mk(CMD_FIND, 0, 32'h5A5A_5A5A));
    allocs_gen = 3;
    drain();

    caps[0] = SZ_MAX; caps[1] = 0; caps[2] = 3000; caps[3] = 29'($urandom_range(1, 268435455));
    caps[4] = SZ_MAX;
    for (int p = 0; p < 5; p++) begin
      set_capacity(caps[p]);
      // table-full run once, then a write to slot 127, a free, an alloc and a free-all
      if (p == 0) begin
        for (int k = 0; k < 130; k++) begin
          cmd_pending.push_back(mk(CMD_ALLOC, 29'($urandom_range(1, 8)), $urandom));
          allocs_gen++;
        end
        cmd_pending.push_back(mk(CMD_WRITE, 0, 0, 0, 7'd127, 1, 0));
        cmd_pending.push_back(mk(CMD_FREE, 0, 0, 32'($urandom_range(1, allocs_gen))));
        cmd_pending.push_back(mk(CMD_ALLOC, 2, 1));
        allocs_gen++;
        cmd_pending.push_back(mk(CMD_FREE_ALL));
      end
      for (int k = 0; k < 140; k++) cmd_pending.push_back(rand_item());
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hw/rtl/bpsm_pkg.sv
hw/rtl/bpsm_ram.sv
hw/rtl/bpsm_datapath.sv
hw/rtl/bpsm_ctrl.sv
hw/rtl/buffer_pool_slot_manager.sv
hw/rtl/bpsm_checker.sv
tb/sv/tb_top.sv
